/* design/upi_pkg.sv */
// shared types, constants and the arctangent table of the pose integrator
package upi_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int CORDIC_ITERS  =
      (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
   localparam int IDX_W = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;

   // heading in q3.13, kept 18 bits wide while a step is in flight
   localparam logic signed [17:0] HEAD_PI     = 18'sd25736;
   localparam logic signed [17:0] HEAD_TWO_PI = 18'sd51472;

   // cordic angle and vector words, q2.30 with headroom
   localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
   localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   typedef enum logic {
      OP_STEP = 1'b0,
      OP_LOAD = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_MUL,
      ST_POS,
      ST_WRAP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic               op;
      logic signed [15:0] linear_speed;
      logic signed [15:0] angular_speed;
      logic        [15:0] step_time;
      logic signed [31:0] load_x;
      logic signed [31:0] load_y;
      logic signed [15:0] load_heading;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pose_x;
      logic signed [31:0] pose_y;
      logic signed [15:0] pose_heading;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] cos_val;
      logic signed [31:0] sin_val;
   } trig_type;

   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] val;
      case (idx)
         5'd0:    val = 30'd843314857;
         5'd1:    val = 30'd497837829;
         5'd2:    val = 30'd263043837;
         5'd3:    val = 30'd133525159;
         5'd4:    val = 30'd67021687;
         5'd5:    val = 30'd33543516;
         5'd6:    val = 30'd16775851;
         5'd7:    val = 30'd8388437;
         5'd8:    val = 30'd4194283;
         5'd9:    val = 30'd2097149;
         5'd10:   val = 30'd1048576;
         5'd11:   val = 30'd524288;
         5'd12:   val = 30'd262144;
         5'd13:   val = 30'd131072;
         5'd14:   val = 30'd65536;
         5'd15:   val = 30'd32768;
         5'd16:   val = 30'd16384;
         5'd17:   val = 30'd8192;
         5'd18:   val = 30'd4096;
         5'd19:   val = 30'd2048;
         5'd20:   val = 30'd1024;
         5'd21:   val = 30'd512;
         5'd22:   val = 30'd256;
         5'd23:   val = 30'd128;
         default: val = 30'd0;
      endcase
      return val;
   endfunction

endpackage

/* design/unicycle_pose_integrator.sv */
// Planar pose integrator: each request either loads the pose (x, y, heading) or advances it
// by one Euler step, and each gives exactly one response with the new pose. The block takes
// one request at a time and holds req_stall high until the response has been taken. A load
// goes straight to the heading wrap and then shows its response. A step first runs the
// iterative cordic, one micro-rotation per cycle, for cosine and sine; then a single 33x17
// multiplier is shared for speed times step time, angular speed times step time for the
// heading increment and the four half-word products of the position increments, followed
// by the saturating position update and the heading wrap before the response is shown.
module unicycle_pose_integrator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  upi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output upi_pkg::rsp_type rsp_data
);

   // multiplier schedule within ST_MUL
   localparam logic [2:0] MS_VD    = 3'd0;
   localparam logic [2:0] MS_WD    = 3'd1;
   localparam logic [2:0] MS_CLO   = 3'd2;
   localparam logic [2:0] MS_CHI   = 3'd3;
   localparam logic [2:0] MS_SLO   = 3'd4;
   localparam logic [2:0] MS_SHI   = 3'd5;
   localparam logic [2:0] MS_DRAIN = 3'd6;

   localparam logic signed [63:0] POS_ROUND = 64'sh20_0000_0000;
   localparam logic signed [32:0] HEAD_ROUND = 33'sd16384;

   upi_pkg::state_type state_ff, state_in;

   logic [2:0]         mstep_ff;
   logic signed [31:0] x_ff;
   logic signed [31:0] y_ff;
   logic signed [15:0] heading_ff;
   logic signed [17:0] hw_ff;
   logic signed [15:0] v_ff;
   logic signed [15:0] w_ff;
   logic        [15:0] dt_ff;
   logic signed [31:0] vd_ff;
   logic signed [17:0] dh_ff;
   logic signed [63:0] acc_x_ff;
   logic signed [63:0] acc_y_ff;

   logic               req_take;
   logic               cordic_start;
   logic               cordic_done;
   upi_pkg::trig_type  trig;
   logic signed [32:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [49:0] mul_p;
   logic signed [32:0] head_sum;
   logic signed [63:0] round_x;
   logic signed [63:0] round_y;
   logic signed [25:0] dx;
   logic signed [25:0] dy;
   logic signed [32:0] x_sum;
   logic signed [32:0] y_sum;
   logic signed [31:0] x_sat;
   logic signed [31:0] y_sat;
   logic               hw_in_range;

   upi_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .heading (heading_ff),
      .done    (cordic_done),
      .trig    (trig)
   );

   upi_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   assign req_take    = req_valid && !req_stall;
   assign hw_in_range = (hw_ff <= upi_pkg::HEAD_PI) && (hw_ff >= -upi_pkg::HEAD_PI);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         upi_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_data.op == upi_pkg::OP_LOAD) begin
                  state_in = upi_pkg::ST_WRAP;
               end else begin
                  state_in = upi_pkg::ST_CORDIC;
               end
            end
         end
         upi_pkg::ST_CORDIC: begin
            if (cordic_done) begin
               state_in = upi_pkg::ST_MUL;
            end
         end
         upi_pkg::ST_MUL: begin
            if (mstep_ff == MS_DRAIN) begin
               state_in = upi_pkg::ST_POS;
            end
         end
         upi_pkg::ST_POS: begin
            state_in = upi_pkg::ST_WRAP;
         end
         upi_pkg::ST_WRAP: begin
            if (hw_in_range) begin
               state_in = upi_pkg::ST_OUT;
            end
         end
         upi_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               state_in = upi_pkg::ST_IDLE;
            end
         end
         default: state_in = upi_pkg::ST_IDLE;
      endcase
   end

   // control outputs and multiplier operands
   always_comb begin
      req_stall    = (state_ff != upi_pkg::ST_IDLE);
      rsp_valid    = (state_ff == upi_pkg::ST_OUT);
      cordic_start = req_take && (req_data.op == upi_pkg::OP_STEP);
      mul_a        = '0;
      mul_b        = '0;
      if (state_ff == upi_pkg::ST_MUL) begin
         case (mstep_ff)
            MS_VD: begin
               mul_a = {v_ff[15], {16{v_ff[15]}}, v_ff};
               mul_b = {1'b0, dt_ff};
            end
            MS_WD: begin
               mul_a = {w_ff[15], {16{w_ff[15]}}, w_ff};
               mul_b = {1'b0, dt_ff};
            end
            MS_CLO: begin
               mul_a = {vd_ff[31], vd_ff};
               mul_b = {1'b0, trig.cos_val[15:0]};
            end
            MS_CHI: begin
               mul_a = {vd_ff[31], vd_ff};
               mul_b = {trig.cos_val[31], trig.cos_val[31:16]};
            end
            MS_SLO: begin
               mul_a = {vd_ff[31], vd_ff};
               mul_b = {1'b0, trig.sin_val[15:0]};
            end
            MS_SHI: begin
               mul_a = {vd_ff[31], vd_ff};
               mul_b = {trig.sin_val[31], trig.sin_val[31:16]};
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   // rounding of the heading and position steps, saturation of the position
   always_comb begin
      head_sum = mul_p[32:0] + HEAD_ROUND;
      round_x  = acc_x_ff + POS_ROUND;
      round_y  = acc_y_ff + POS_ROUND;
      dx       = round_x[63:38];
      dy       = round_y[63:38];
      x_sum    = {x_ff[31], x_ff} + {{7{dx[25]}}, dx};
      y_sum    = {y_ff[31], y_ff} + {{7{dy[25]}}, dy};
      if (x_sum[32] != x_sum[31]) begin
         x_sat = {x_sum[32], {31{~x_sum[32]}}};
      end else begin
         x_sat = x_sum[31:0];
      end
      if (y_sum[32] != y_sum[31]) begin
         y_sat = {y_sum[32], {31{~y_sum[32]}}};
      end else begin
         y_sat = y_sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= upi_pkg::ST_IDLE;
         mstep_ff   <= MS_VD;
         x_ff       <= '0;
         y_ff       <= '0;
         heading_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == upi_pkg::ST_MUL) begin
            mstep_ff <= 3'(mstep_ff + 1'b1);
         end else begin
            mstep_ff <= MS_VD;
         end
         if (req_take && (req_data.op == upi_pkg::OP_LOAD)) begin
            x_ff <= req_data.load_x;
            y_ff <= req_data.load_y;
         end else if (state_ff == upi_pkg::ST_POS) begin
            x_ff <= x_sat;
            y_ff <= y_sat;
         end
         if ((state_ff == upi_pkg::ST_WRAP) && hw_in_range) begin
            heading_ff <= hw_ff[15:0];
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         v_ff  <= req_data.linear_speed;
         w_ff  <= req_data.angular_speed;
         dt_ff <= req_data.step_time;
         hw_ff <= {{2{req_data.load_heading[15]}}, req_data.load_heading};
      end else if (state_ff == upi_pkg::ST_POS) begin
         hw_ff <= {{2{heading_ff[15]}}, heading_ff} + dh_ff;
      end else if (state_ff == upi_pkg::ST_WRAP) begin
         if (hw_ff > upi_pkg::HEAD_PI) begin
            hw_ff <= hw_ff - upi_pkg::HEAD_TWO_PI;
         end else if (hw_ff < -upi_pkg::HEAD_PI) begin
            hw_ff <= hw_ff + upi_pkg::HEAD_TWO_PI;
         end
      end
      // the product seen at a step is the one issued at the step before it
      if (state_ff == upi_pkg::ST_MUL) begin
         case (mstep_ff)
            MS_WD:    vd_ff    <= mul_p[31:0];
            MS_CLO:   dh_ff    <= head_sum[32:15];
            MS_CHI:   acc_x_ff <= {{14{mul_p[49]}}, mul_p};
            MS_SLO:   acc_x_ff <= acc_x_ff + {mul_p[47:0], 16'h0};
            MS_SHI:   acc_y_ff <= {{14{mul_p[49]}}, mul_p};
            MS_DRAIN: acc_y_ff <= acc_y_ff + {mul_p[47:0], 16'h0};
            default:  vd_ff    <= vd_ff;
         endcase
      end
   end

   always_comb begin
      rsp_data.pose_x       = x_ff;
      rsp_data.pose_y       = y_ff;
      rsp_data.pose_heading = heading_ff;
   end

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == upi_pkg::ST_CORDIC) || (state_ff == upi_pkg::ST_WRAP))
      else $error("accepted request did not start cordic or wrap");

   a_heading_wrapped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.pose_heading <= 16'sd25736) &&
                     (rsp_data.pose_heading >= -16'sd25736)))
      else $error("response heading outside minus pi to pi");

   a_cordic_done_in_place: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> (state_ff == upi_pkg::ST_CORDIC))
      else $error("cordic finished outside its state");

   a_single_response: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("response repeated after it was taken");

endmodule

/* design/upi_cordic.sv */
// iterative rotation-mode cordic: one micro-rotation per cycle
module upi_cordic (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [15:0]    heading,
   output logic                  done,
   output upi_pkg::trig_type     trig
);

   logic                     busy_ff;
   logic                     done_ff;
   logic [upi_pkg::IDX_W-1:0] idx_ff;
   logic                     flip_ff;
   logic signed [33:0]       x_ff;
   logic signed [33:0]       y_ff;
   logic signed [33:0]       z_ff;

   logic signed [33:0] z_full;
   logic signed [33:0] z_start;
   logic               flip_start;
   logic signed [33:0] x_shift;
   logic signed [33:0] y_shift;
   logic signed [33:0] atan_val;
   logic               last;
   logic signed [33:0] cos_full;
   logic signed [33:0] sin_full;

   // heading q3.13 to q2.30, folded into the right half plane
   always_comb begin
      z_full = $signed({heading[15], heading, 17'b0});
      if (z_full > upi_pkg::Q30_HALF_PI) begin
         z_start    = z_full - upi_pkg::Q30_PI;
         flip_start = 1'b1;
      end else if (z_full < -upi_pkg::Q30_HALF_PI) begin
         z_start    = z_full + upi_pkg::Q30_PI;
         flip_start = 1'b1;
      end else begin
         z_start    = z_full;
         flip_start = 1'b0;
      end
   end

   always_comb begin
      x_shift  = x_ff >>> idx_ff;
      y_shift  = y_ff >>> idx_ff;
      atan_val = $signed({4'b0, upi_pkg::atan_q30(5'(idx_ff))});
      last     = (idx_ff == upi_pkg::IDX_W'(upi_pkg::CORDIC_ITERS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && last;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         idx_ff  <= '0;
         flip_ff <= flip_start;
         x_ff    <= upi_pkg::CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= z_start;
      end else if (busy_ff) begin
         idx_ff <= upi_pkg::IDX_W'(idx_ff + 1'b1);
         if (z_ff >= 0) begin
            x_ff <= x_ff - y_shift;
            y_ff <= y_ff + x_shift;
            z_ff <= z_ff - atan_val;
         end else begin
            x_ff <= x_ff + y_shift;
            y_ff <= y_ff - x_shift;
            z_ff <= z_ff + atan_val;
         end
      end
   end

   always_comb begin
      cos_full     = flip_ff ? -x_ff : x_ff;
      sin_full     = flip_ff ? -y_ff : y_ff;
      trig.cos_val = cos_full[31:0];
      trig.sin_val = sin_full[31:0];
   end

   assign done = done_ff;

endmodule

/* design/upi_mul.sv */
// shared signed multiplier with a registered product
module upi_mul (
   input  logic               clock,
   input  logic signed [32:0] mul_a,
   input  logic signed [16:0] mul_b,
   output logic signed [49:0] mul_p
);

   logic signed [49:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign mul_p = prod_ff;

endmodule

/* test/unicycle_pose_integrator_check.sv */
// pose checker: predicts each response from the accepted requests and compares it
module unicycle_pose_integrator_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  upi_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  upi_pkg::rsp_type rsp_data,
   output int               failures,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     ROTATIONS  =
      (upi_pkg::CORDIC_STAGES < 24) ? upi_pkg::CORDIC_STAGES : 24;
   localparam longint HALF_TURN  = 25736;
   localparam longint FULL_TURN  = 51472;
   localparam longint PI_Q30     = 64'sd3373259426;
   localparam longint RIGHT_Q30  = 64'sd1686629713;
   localparam longint UNIT_GAIN  = 64'sd652032874;

   // arctangent of 2^-i, q2.30, rounded to nearest
   longint arctan_q30 [24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128
   };

   longint           pose_x_q16;
   longint           pose_y_q16;
   longint           heading_q13;
   upi_pkg::rsp_type expected_poses [$];

   function automatic longint wrap_angle(input longint h);
      longint a = h;
      repeat (3) if (a > HALF_TURN) a -= FULL_TURN;
      repeat (3) if (a < -HALF_TURN) a += FULL_TURN;
      return a;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // rotation-mode cordic, cosine and sine in q2.30
   function automatic void heading_trig(input longint h, output longint c, output longint s);
      longint z;
      longint vx;
      longint vy;
      longint sx;
      longint sy;
      bit     flip;
      z    = h * 131072;
      vx   = UNIT_GAIN;
      vy   = 0;
      flip = 1'b0;
      // fold the back half-plane onto the front one
      if (z > RIGHT_Q30) begin
         z    = z - PI_Q30;
         flip = 1'b1;
      end else if (z < -RIGHT_Q30) begin
         z    = z + PI_Q30;
         flip = 1'b1;
      end
      for (int i = 0; i < ROTATIONS; i++) begin
         sx = vx >>> i;
         sy = vy >>> i;
         if (z >= 0) begin
            vx = vx - sy;
            vy = vy + sx;
            z  = z - arctan_q30[i];
         end else begin
            vx = vx + sy;
            vy = vy - sx;
            z  = z + arctan_q30[i];
         end
      end
      c = flip ? -vx : vx;
      s = flip ? -vy : vy;
   endfunction

   function automatic upi_pkg::rsp_type advance_pose(input upi_pkg::req_type r);
      upi_pkg::rsp_type p;
      longint           v;
      longint           w;
      longint           dt;
      longint           c;
      longint           s;
      if (r.op == upi_pkg::OP_LOAD) begin
         pose_x_q16  = longint'(r.load_x);
         pose_y_q16  = longint'(r.load_y);
         heading_q13 = wrap_angle(longint'(r.load_heading));
      end else begin
         v  = longint'(r.linear_speed);
         w  = longint'(r.angular_speed);
         dt = longint'({48'd0, r.step_time});
         heading_trig(heading_q13, c, s);
         pose_x_q16  = clamp32(pose_x_q16 + ((v * c * dt + (64'sd1 <<< 37)) >>> 38));
         pose_y_q16  = clamp32(pose_y_q16 + ((v * s * dt + (64'sd1 <<< 37)) >>> 38));
         heading_q13 = wrap_angle(heading_q13 + ((w * dt + (64'sd1 <<< 14)) >>> 15));
      end
      p.pose_x       = pose_x_q16[31:0];
      p.pose_y       = pose_y_q16[31:0];
      p.pose_heading = heading_q13[15:0];
      return p;
   endfunction

   initial begin
      failures = 0;
      pending  = 0;
   end

   always @(posedge clock) begin
      upi_pkg::rsp_type e;
      if (reset) begin
         pose_x_q16  = 0;
         pose_y_q16  = 0;
         heading_q13 = 0;
         expected_poses.delete();
         pending = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_poses.size() == 0) begin
               $error("response with no request outstanding: x %0d y %0d heading %0d",
                      rsp_data.pose_x, rsp_data.pose_y, rsp_data.pose_heading);
               failures++;
            end else begin
               e = expected_poses.pop_front();
               if (rsp_data.pose_x !== e.pose_x) begin
                  $error("pose_x: expected %0d, got %0d", e.pose_x, rsp_data.pose_x);
                  failures++;
               end
               if (rsp_data.pose_y !== e.pose_y) begin
                  $error("pose_y: expected %0d, got %0d", e.pose_y, rsp_data.pose_y);
                  failures++;
               end
               if (rsp_data.pose_heading !== e.pose_heading) begin
                  $error("pose_heading: expected %0d, got %0d",
                         e.pose_heading, rsp_data.pose_heading);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_poses.push_back(advance_pose(req_data));
         pending = expected_poses.size();
      end
   end

endmodule

/* test/unicycle_pose_integrator_test.sv */
// top of the pose integrator bench: clock, reset, request and response traffic, verdict
module unicycle_pose_integrator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1525;
   localparam int QUIET_LIMIT  = 2000;
   localparam int SETTLE       = 60;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   upi_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   upi_pkg::rsp_type rsp_data;
   int               failures;
   int               pending;
   int               idle_max;
   int               quiet_cycles;

   unicycle_pose_integrator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   unicycle_pose_integrator_check pose_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic upi_pkg::req_type make_req(input upi_pkg::op_type op,
                                                 input logic [15:0] v,
                                                 input logic [15:0] w, input logic [15:0] dt,
                                                 input logic [31:0] lx, input logic [31:0] ly,
                                                 input logic [15:0] lh);
      upi_pkg::req_type r;
      r.op            = op;
      r.linear_speed  = v;
      r.angular_speed = w;
      r.step_time     = dt;
      r.load_x        = lx;
      r.load_y        = ly;
      r.load_heading  = lh;
      return r;
   endfunction

   task automatic send_request(input upi_pkg::req_type r);
      int gap;
      gap = $urandom_range(idle_max, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic step(input logic [15:0] v, input logic [15:0] w, input logic [15:0] dt);
      send_request(make_req(upi_pkg::OP_STEP, v, w, dt, 32'd0, 32'd0, 16'd0));
   endtask

   task automatic load(input logic [31:0] lx, input logic [31:0] ly, input logic [15:0] lh);
      send_request(make_req(upi_pkg::OP_LOAD, 16'd0, 16'd0, 16'd0, lx, ly, lh));
   endtask

   // response side holds off each response for a random number of cycles
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         hold = $urandom_range(idle_max, 0);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      idle_max     = 10;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, saturation, wrap and quadrant edges
      step(16'sd32767, 16'sd0, 16'hffff);
      step(-16'sd32768, -16'sd32768, 16'hffff);
      send_request(make_req(upi_pkg::OP_STEP, 16'sd12345, 16'sd4321, 16'd0,
                            32'hffff_ffff, 32'hffff_ffff, 16'hffff));
      send_request(make_req(upi_pkg::OP_LOAD, 16'hffff, 16'hffff, 16'hffff,
                            32'h7fff_ffff, 32'h8000_0000, 16'sd0));
      step(16'sd32767, 16'sd32767, 16'hffff);
      load(32'h8000_0000, 32'h7fff_ffff, 16'sd25736);
      step(16'sd32767, 16'sd0, 16'hffff);
      load(32'h7fff_0000, 32'h8000_ffff, -16'sd12868);
      step(16'sd32767, 16'sd0, 16'hffff);
      load(32'd0, 32'h7fff_ff00, 16'sd12868);
      step(16'sd32767, 16'sd0, 16'hffff);
      load(32'd0, 32'd0, 16'sd12867);
      step(16'sd256, 16'sd0, 16'h8000);
      load(32'd0, 32'd0, -16'sd12867);
      step(-16'sd256, 16'sd0, 16'h8000);
      load(32'd0, 32'd0, -16'sd25736);
      step(16'sd32767, 16'sd0, 16'hffff);
      load(32'd0, 32'd0, 16'sh7fff);
      load(32'd0, 32'd0, 16'sh8000);
      load(32'd0, 32'd0, 16'sd25737);
      load(32'd0, 32'd0, -16'sd25737);
      step(16'sd0, 16'sd32767, 16'hffff);
      step(16'sd0, 16'sd32767, 16'hffff);
      step(16'sd0, -16'sd32768, 16'hffff);

      // random: mostly steps, with loads scattered in
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         logic [31:0] lx;
         logic [31:0] ly;
         logic [15:0] lh;
         logic [15:0] v;
         logic [15:0] dt;
         // every third stretch runs with no idling at all
         if (n % 50 == 0)
            idle_max = ((n / 50) % 3 == 2) ? 0 : 10;
         if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
               0: lx = $urandom;
               1: lx = 32'h7fff_ffff - $urandom_range(32'h00ff_ffff);
               2: lx = 32'h8000_0000 + $urandom_range(32'h00ff_ffff);
               default: lx = $urandom_range(32'h01ff_ffff) - 32'h0100_0000;
            endcase
            case ($urandom_range(3))
               0: ly = $urandom;
               1: ly = 32'h7fff_ffff - $urandom_range(32'h00ff_ffff);
               2: ly = 32'h8000_0000 + $urandom_range(32'h00ff_ffff);
               default: ly = $urandom_range(32'h01ff_ffff) - 32'h0100_0000;
            endcase
            if ($urandom_range(3) == 0)
               lh = 16'($urandom);
            else
               lh = 16'($urandom_range(51472) - 25736);
            send_request(make_req(upi_pkg::OP_LOAD, 16'($urandom), 16'($urandom),
                                  16'($urandom), lx, ly, lh));
         end else begin
            v = ($urandom_range(9) < 7) ? 16'($urandom) : 16'($urandom_range(2047) - 1024);
            case ($urandom_range(9))
               0:       dt = 16'd0;
               1:       dt = 16'hffff;
               2, 3:    dt = 16'($urandom_range(255));
               default: dt = 16'($urandom);
            endcase
            send_request(make_req(upi_pkg::OP_STEP, v, 16'($urandom), dt, $urandom,
                                  $urandom, 16'($urandom)));
         end
      end
      req_valid <= 1'b0;

      wait (pending == 0);
      repeat (SETTLE) @(posedge clock);
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
